>>> rtl/letter_frequency_histogram_core_defines.svh
// Assertion macros for the letter frequency histogram core.
// LFH_ASSERT is disabled while reset is asserted; LFH_ASSERT_ALWAYS is checked at every edge.
`ifndef LETTER_FREQUENCY_HISTOGRAM_CORE_DEFINES_SVH
`define LETTER_FREQUENCY_HISTOGRAM_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define LFH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define LFH_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define LFH_ASSERT(lbl, prop, msg)
`define LFH_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> rtl/lfh_pkg.sv
`default_nettype none

package lfh_pkg;

  // Table geometry and count width
  localparam int unsigned ALPHABET_SIZE = 26;
  localparam int unsigned COUNT_W       = 24;
  localparam int unsigned LETTER_W      = 5;
  localparam int unsigned SKIP_W        = 24;
  localparam int unsigned PERIOD_W      = 8;
  localparam int unsigned CFG_IDX_W     = 1;
  localparam int unsigned CFG_DATA_W    = 24;

  localparam logic [LETTER_W-1:0] LAST_LETTER = LETTER_W'(ALPHABET_SIZE - 1);
  localparam logic [COUNT_W-1:0]  COUNT_MAX   = '1;

  // ASCII bounds of the two letter ranges
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;

  // Input command codes
  typedef enum logic [1:0] {
    CMD_DATA    = 2'd0,
    CMD_REPORT  = 2'd1,
    CMD_RESTART = 2'd2
  } lfh_cmd_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SKIP_COUNT = 1'b0,
    REG_PERIOD     = 1'b1
  } lfh_reg_e;

  // Controller states
  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_REPORT = 1'b1
  } lfh_state_e;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] data_byte;
  } lfh_in_t;

  typedef struct packed {
    logic [LETTER_W-1:0] letter;
    logic [COUNT_W-1:0]  letter_count;
    logic [COUNT_W-1:0]  total_count;
    logic                last;
  } lfh_out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic count_en;
    logic clear_en;
    logic rpt_start;
    logic rpt_load;
  } lfh_ctrl_t;

  // Datapath to controller status
  typedef struct packed {
    logic slot_free;
    logic idx_last;
  } lfh_status_t;

  // Saturating increment of a count
  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    logic [COUNT_W-1:0] r;
    r = (v == COUNT_MAX) ? v : v + COUNT_W'(1);
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/letter_frequency_histogram_core.sv
// Letter frequency histogram core. Counts the letters A to Z, with upper and
// lower case folded, in a stream of byte transfers. After a restart the first
// skip_count letters are dropped, then one letter in every period letters is
// counted, starting with the first. Data bytes, restarts and unknown commands
// are taken whenever no report runs, and such transfers may follow each other
// in every cycle: each counted letter does a read-modify-write of one table
// entry in its own cycle. A restart clears the table through per-entry valid
// flags, so no clearing pass is needed after reset or restart. A report
// command sends 26 result transfers, A to Z, with the last flag on Z; the
// input is stalled while they are produced one after another, since the table
// has a single read port feeding a single output register. Counts and the
// total saturate at 2^24 - 1. Configuration writes are always taken:
// skip_count applies at the next restart, period at the next reload of the
// phase counter.
`default_nettype none

module letter_frequency_histogram_core (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire lfh_pkg::lfh_in_t               in_data_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output lfh_pkg::lfh_out_t                   out_data_o,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [lfh_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [lfh_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import lfh_pkg::*;

  lfh_ctrl_t   cmd;
  lfh_status_t status;

  // Accept configuration writes in every cycle
  assign cfg_ready_o = 1'b1;

  lfh_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_command_i (in_data_i.command),
    .in_stall_o   (in_stall_o),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  lfh_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .data_byte_i (in_data_i.data_byte),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

>>> rtl/lfh_ctrl.sv
`default_nettype none

`include "letter_frequency_histogram_core_defines.svh"

module lfh_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire logic [1:0]          in_command_i,
  output logic                     in_stall_o,
  input  wire lfh_pkg::lfh_status_t status_i,
  output lfh_pkg::lfh_ctrl_t       cmd_o
);
  import lfh_pkg::*;

  lfh_state_e state_q, state_d;
  logic       accept;

  // Hold the state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Decode accepted commands and advance the report sequence
  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    accept     = in_valid_i && (state_q == ST_IDLE);
    cmd_o      = '0;
    state_d    = state_q;
    case (state_q)
      ST_IDLE: begin
        cmd_o.count_en  = accept && (in_command_i == CMD_DATA);
        cmd_o.clear_en  = accept && (in_command_i == CMD_RESTART);
        cmd_o.rpt_start = accept && (in_command_i == CMD_REPORT);
        if (cmd_o.rpt_start) begin
          state_d = ST_REPORT;
        end
      end
      ST_REPORT: begin
        cmd_o.rpt_load = status_i.slot_free;
        if (status_i.slot_free && status_i.idx_last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  `LFH_ASSERT(a_rpt_enters, (accept && in_command_i == CMD_REPORT) |=> (state_q == ST_REPORT), "report transfer did not start a report")
  `LFH_ASSERT(a_rpt_ends, (cmd_o.rpt_load && status_i.idx_last) |=> (state_q == ST_IDLE), "report did not end after last letter")
  `LFH_ASSERT_ALWAYS(a_excl, !(cmd_o.rpt_load && (cmd_o.count_en || cmd_o.clear_en)), "table update during report")

endmodule

`default_nettype wire

>>> rtl/lfh_datapath.sv
`default_nettype none

`include "letter_frequency_histogram_core_defines.svh"

module lfh_datapath (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic [7:0]                        data_byte_i,
  input  wire logic                              cfg_we_i,
  input  wire logic [lfh_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [lfh_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  wire lfh_pkg::lfh_ctrl_t                cmd_i,
  output lfh_pkg::lfh_status_t                   status_o,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output lfh_pkg::lfh_out_t                      out_data_o
);
  import lfh_pkg::*;

  // Configuration registers
  logic [SKIP_W-1:0]   skip_count_q;
  logic [PERIOD_W-1:0] period_q;

  // Counting state
  logic [COUNT_W-1:0]       table_q [ALPHABET_SIZE];
  logic [ALPHABET_SIZE-1:0] entry_vld_q;
  logic [COUNT_W-1:0]       total_q;
  logic [SKIP_W-1:0]        skip_left_q;
  logic [PERIOD_W-1:0]      phase_left_q;

  // Report sequencing and output register
  logic [LETTER_W-1:0] rpt_idx_q;
  logic                out_valid_q;
  lfh_out_t            out_q;

  logic                is_upper, is_lower, is_letter;
  logic [LETTER_W-1:0] byte_idx;
  logic [LETTER_W-1:0] rd_addr;
  logic [COUNT_W-1:0]  rd_val;
  logic                do_count;
  logic                out_take;

  // Classify the byte and fold its case
  always_comb begin
    is_upper  = (data_byte_i >= CHAR_UPPER_A) && (data_byte_i <= CHAR_UPPER_Z);
    is_lower  = (data_byte_i >= CHAR_LOWER_A) && (data_byte_i <= CHAR_LOWER_Z);
    is_letter = is_upper || is_lower;
    byte_idx  = is_upper ? LETTER_W'(data_byte_i - CHAR_UPPER_A)
                         : LETTER_W'(data_byte_i - CHAR_LOWER_A);
    do_count  = cmd_i.count_en && is_letter && (skip_left_q == '0) &&
                (phase_left_q == PERIOD_W'(1));
  end

  // Share one table read port between counting and reporting
  always_comb begin
    rd_addr = cmd_i.rpt_load ? rpt_idx_q : byte_idx;
    rd_val  = entry_vld_q[rd_addr] ? table_q[rd_addr] : '0;
  end

  // Take configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_count_q <= '0;
      period_q     <= PERIOD_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_SKIP_COUNT: skip_count_q <= SKIP_W'(cfg_data_i);
        REG_PERIOD:     period_q     <= cfg_data_i[PERIOD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Update skip and phase counters, total and entry valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_vld_q  <= '0;
      total_q      <= '0;
      skip_left_q  <= '0;
      phase_left_q <= PERIOD_W'(1);
    end else if (cmd_i.clear_en) begin
      entry_vld_q  <= '0;
      total_q      <= '0;
      skip_left_q  <= skip_count_q;
      phase_left_q <= PERIOD_W'(1);
    end else if (cmd_i.count_en && is_letter) begin
      if (skip_left_q != '0) begin
        skip_left_q <= skip_left_q - SKIP_W'(1);
      end else if (phase_left_q == PERIOD_W'(1)) begin
        entry_vld_q[byte_idx] <= 1'b1;
        total_q               <= sat_inc(total_q);
        // A period of zero behaves as one
        phase_left_q <= (period_q == '0) ? PERIOD_W'(1) : period_q;
      end else begin
        phase_left_q <= phase_left_q - PERIOD_W'(1);
      end
    end
  end

  // Write the incremented count back
  always_ff @(posedge clk_i) begin
    if (do_count) begin
      table_q[byte_idx] <= sat_inc(rd_val);
    end
  end

  // Step through the letters during a report
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rpt_idx_q <= '0;
    end else if (cmd_i.rpt_start) begin
      rpt_idx_q <= '0;
    end else if (cmd_i.rpt_load) begin
      rpt_idx_q <= rpt_idx_q + LETTER_W'(1);
    end
  end

  assign out_take = out_valid_q && !out_stall_i;

  // Hold the result until its transfer completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.rpt_load) begin
      out_valid_q <= 1'b1;
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rpt_load) begin
      out_q.letter       <= rpt_idx_q;
      out_q.letter_count <= rd_val;
      out_q.total_count  <= total_q;
      out_q.last         <= (rpt_idx_q == LAST_LETTER);
    end
  end

  assign status_o.slot_free = !out_valid_q || !out_stall_i;
  assign status_o.idx_last  = (rpt_idx_q == LAST_LETTER);
  assign out_valid_o        = out_valid_q;
  assign out_data_o         = out_q;

  `LFH_ASSERT(a_last_flag, out_valid_q |-> (out_q.last == (out_q.letter == LAST_LETTER)), "last flag does not match letter")
  `LFH_ASSERT(a_phase_nz, phase_left_q != '0, "phase counter reached zero")

endmodule

`default_nettype wire
